// File: hdl/sine_oscillator_mix_with_release_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sine oscillator mixer
// Checks sampled on the rising clock edge, quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef SINE_OSCILLATOR_MIX_WITH_RELEASE_ASSERT_SVH
`define SINE_OSCILLATOR_MIX_WITH_RELEASE_ASSERT_SVH

// check cons in the same cycle as ante
`define SOMR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define SOMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/somr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// somr_pkg
// Codes, field widths and the sine table generator of the oscillator mixer.
// ----------------------------------------------------------------------------
package somr_pkg;

   localparam int OPCODE_W   = 2;
   localparam int MIX_W      = 16;
   localparam int AMP_W      = 17;
   localparam int INC_W      = 31;
   localparam int STEP_W     = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [OPCODE_W-1:0] OP_MIX     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_START   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] MODE_DONE = 2'd0;
   localparam logic [1:0] MODE_PLAY = 2'd1;
   localparam logic [1:0] MODE_REL  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_INC = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_VOL = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REL_STEP  = 2'd2;

   localparam logic [AMP_W-1:0]  START_VOL_RESET = 17'd65536;
   localparam logic [STEP_W-1:0] REL_STEP_RESET  = 16'd7;

   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned COEF_A1 = 64'd1686629713;
   localparam longint unsigned COEF_B3 = 64'd693598668;
   localparam longint unsigned COEF_B5 = Q30_ONE + COEF_B3 - COEF_A1;

   // quarter-wave sine magnitude, Q30 odd polynomial, rounded to peak
   function automatic longint unsigned sine_mag(input longint unsigned idx,
                                                input int unsigned qbits,
                                                input int unsigned sample_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned peak;
      longint unsigned mag;
      peak = (64'd1 << (sample_bits - 1)) - 64'd1;
      x    = idx << (30 - qbits);
      x2   = (x * x) >> 30;
      t    = COEF_B3 - ((COEF_B5 * x2) >> 30);
      t    = COEF_A1 - ((t * x2) >> 30);
      t    = (t * x) >> 30;
      mag  = (t * peak + (64'd1 << 29)) >> 30;
      if (mag > peak) begin
         mag = peak;
      end
      return mag;
   endfunction

endpackage

// File: hdl/sine_oscillator_mix_with_release.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_oscillator_mix_with_release
// Phase-accumulator sine tone mixed into a sample stream, with linear release.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one item per handshake: tuser is the opcode (mix, start,
//   release), tdata the incoming 16-bit mix sample. rsp_ returns exactly one
//   item per request: tdata is the mixed sample, tuser the finished flag.
//   csr_ writes phase increment, start volume and release step; write only
//   while no item is in flight.
//   One item is taken every cycle unless rsp_tready holds a full pipeline;
//   the phase, volume and mode update settles in the accept cycle, followed by
//   table read, volume multiply and the add, each in its own register stage.
//   Reset clears the pipeline, sets phase and volume to zero, the mode to
//   finished and the registers to their defaults.
//   When rsp_tready is low the output item holds; bubbles further back still
//   fill, and req_tready drops once all three stages are occupied.
// ----------------------------------------------------------------------------
module sine_oscillator_mix_with_release #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] mix_in
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] mix_out
   output logic        rsp_tuser,   // [0] finished
   input  logic                                 csr_we,
   input  logic [somr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [somr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int MAG_W  = SAMPLE_BITS - 1;
   localparam int PROD_W = somr_pkg::AMP_W + MAG_W;
   localparam logic [15:0] OUT_MASK = (SAMPLE_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << SAMPLE_BITS) - 32'd1);

   logic [somr_pkg::INC_W-1:0]  phase_inc_ff;
   logic [somr_pkg::AMP_W-1:0]  start_vol_ff;
   logic [somr_pkg::STEP_W-1:0] rel_step_ff;

   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic [somr_pkg::AMP_W-1:0] amp_ff, amp_in;
   logic [1:0]                 mode_ff, mode_in;
   logic                       play;

   logic                       req_acc;
   logic [1:0]                 op;
   logic                       rdy2, rdy3;

   logic                       s1_valid_ff, s1_play_ff, s1_fin_ff;
   logic [somr_pkg::AMP_W-1:0] s1_amp_ff;
   logic [15:0]                s1_mix_ff;
   logic [MAG_W-1:0]           rom_mag;
   logic                       rom_neg;

   logic [PROD_W-1:0]          prod;
   logic [15:0]                term_in;
   logic                       s2_valid_ff, s2_play_ff, s2_neg_ff, s2_fin_ff;
   logic [15:0]                s2_term_ff, s2_mix_ff;

   logic [15:0]                sum;
   logic [15:0]                out_in;
   logic                       out_valid_ff, out_fin_ff;
   logic [15:0]                out_data_ff;

   // ---- flow control
   assign rdy3       = !out_valid_ff || rsp_tready;
   assign rdy2       = !s2_valid_ff || rdy3;
   assign req_tready = !s1_valid_ff || rdy2;
   assign req_acc    = req_tvalid && req_tready;
   assign op         = req_tuser;

   // ---- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= '0;
         start_vol_ff <= somr_pkg::START_VOL_RESET;
         rel_step_ff  <= somr_pkg::REL_STEP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            somr_pkg::CSR_PHASE_INC: phase_inc_ff <= csr_wdata;
            somr_pkg::CSR_START_VOL: start_vol_ff <= csr_wdata[somr_pkg::AMP_W-1:0];
            somr_pkg::CSR_REL_STEP:  rel_step_ff  <= csr_wdata[somr_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- oscillator state
   always_comb begin
      phase_in = phase_ff;
      amp_in   = amp_ff;
      mode_in  = mode_ff;
      play     = 1'b0;
      if (req_acc) begin
         case (op)
            somr_pkg::OP_START: begin
               phase_in = '0;
               amp_in   = start_vol_ff;
               mode_in  = somr_pkg::MODE_PLAY;
            end
            somr_pkg::OP_RELEASE: begin
               if (mode_ff == somr_pkg::MODE_PLAY) begin
                  mode_in = somr_pkg::MODE_REL;
               end
            end
            somr_pkg::OP_MIX: begin
               if (mode_ff == somr_pkg::MODE_PLAY) begin
                  play = 1'b1;
               end else if (mode_ff == somr_pkg::MODE_REL) begin
                  if (somr_pkg::AMP_W'(rel_step_ff) > amp_ff) begin
                     amp_in  = '0;
                     mode_in = somr_pkg::MODE_DONE;
                  end else begin
                     amp_in = amp_ff - somr_pkg::AMP_W'(rel_step_ff);
                     play   = 1'b1;
                  end
               end
               if (play) begin
                  phase_in = phase_ff + PHASE_BITS'(phase_inc_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         amp_ff   <= '0;
         mode_ff  <= somr_pkg::MODE_DONE;
      end else begin
         phase_ff <= phase_in;
         amp_ff   <= amp_in;
         mode_ff  <= mode_in;
      end
   end

   // ---- stage 1: table read from the phase before the advance
   somr_sine_rom #(
      .ADDR_BITS   (SINE_ADDR_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rom (
      .clock  (clock),
      .load   (req_acc),
      .addr   (phase_ff[PHASE_BITS-1 -: SINE_ADDR_BITS]),
      .mag_ff (rom_mag),
      .neg_ff (rom_neg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_play_ff <= play;
         s1_amp_ff  <= amp_in;
         s1_mix_ff  <= req_tdata;
         s1_fin_ff  <= (mode_in == somr_pkg::MODE_DONE);
      end
   end

   // ---- stage 2: volume multiply
   assign prod    = PROD_W'(s1_amp_ff) * PROD_W'(rom_mag);
   assign term_in = s1_play_ff ? 16'(prod >> 16) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && s1_valid_ff) begin
         s2_term_ff <= term_in;
         s2_play_ff <= s1_play_ff;
         s2_neg_ff  <= rom_neg;
         s2_mix_ff  <= s1_mix_ff;
         s2_fin_ff  <= s1_fin_ff;
      end
   end

   // ---- stage 3: wrapping add into the output register
   assign sum    = s2_neg_ff ? (s2_mix_ff - s2_term_ff) : (s2_mix_ff + s2_term_ff);
   assign out_in = s2_play_ff ? (sum & OUT_MASK) : s2_mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy3) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && s2_valid_ff) begin
         out_data_ff <= out_in;
         out_fin_ff  <= s2_fin_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_fin_ff;

   // ---- assertions
`include "sine_oscillator_mix_with_release_assert.svh"

   `SOMR_ASSERT_NEXT(a_start_loads, clock, reset, req_acc && (op == somr_pkg::OP_START), (phase_ff == '0) && (mode_ff == somr_pkg::MODE_PLAY) && (amp_ff == $past(start_vol_ff)), "start item did not load the oscillator state")
   `SOMR_ASSERT_NOW(a_done_silent, clock, reset, mode_ff == somr_pkg::MODE_DONE, amp_ff == '0, "finished mode with nonzero volume")
   `SOMR_ASSERT_NEXT(a_done_holds_phase, clock, reset, req_acc && (mode_ff == somr_pkg::MODE_DONE) && (op != somr_pkg::OP_START), $stable(phase_ff), "phase advanced while finished")

endmodule

// File: hdl/somr_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// somr_sine_rom
// Quarter-wave sine table with quadrant folding and a registered read.
// ----------------------------------------------------------------------------
module somr_sine_rom #(
   parameter int ADDR_BITS   = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [ADDR_BITS-1:0]   addr,
   output logic [SAMPLE_BITS-2:0] mag_ff,
   output logic                   neg_ff
);

   localparam int MAG_W = SAMPLE_BITS - 1;
   localparam int QBITS = ADDR_BITS - 2;
   localparam int QSIZE = 1 << QBITS;
   localparam logic [MAG_W-1:0] MAG_TOP =
      MAG_W'(somr_pkg::sine_mag(64'(QSIZE), QBITS, SAMPLE_BITS));

   logic [MAG_W-1:0] quarter [QSIZE];
   logic [1:0]       quad;
   logic [QBITS-1:0] idx;
   logic [QBITS-1:0] fold_idx;
   logic [MAG_W-1:0] mag_in;
   logic             neg_in;

   for (genvar g = 0; g < QSIZE; g++) begin : g_quarter
      assign quarter[g] = MAG_W'(somr_pkg::sine_mag(64'(g), QBITS, SAMPLE_BITS));
   end

   always_comb begin
      quad     = addr[ADDR_BITS-1 -: 2];
      idx      = addr[QBITS-1:0];
      fold_idx = quad[0] ? (-idx) : idx;
      if (quad[0] && (idx == '0)) begin
         mag_in = MAG_TOP;
      end else begin
         mag_in = quarter[fold_idx];
      end
      neg_in = quad[1];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

endmodule
